FILE: design/shec_pkg.sv
// shec_pkg: shared widths and the control bundle for the hamming encoder cells
// used by shec_cell and streaming_symbol_hamming_encoder_core
package shec_pkg;

  localparam int POS_W = 16;
  localparam int SYM_W = 8;

  typedef struct packed {
    logic acc_en;
    logic load;
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: design/shec_cell.sv
// shec_cell: one check-symbol cell of the encoder row, accumulates and shifts out
// depends on shec_pkg for the control bundle
module shec_cell #(
  parameter int SYMBOL_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  shec_pkg::cell_ctl_t    ctl,
  input  logic [SYMBOL_BITS-1:0] sym,
  input  logic                   pbit,
  input  logic                   ge,
  input  logic [SYMBOL_BITS-1:0] acc_in,
  input  logic                   vld_in,
  output logic [SYMBOL_BITS-1:0] acc,
  output logic                   vld
);

  logic [SYMBOL_BITS-1:0] acc_r, acc_nxt;
  logic                   vld_r, vld_nxt;

  always_comb begin
    acc_nxt = acc_r;
    vld_nxt = vld_r;
    if (ctl.clear) begin
      acc_nxt = '0;
      vld_nxt = 1'b0;
    end else if (ctl.shift) begin
      acc_nxt = acc_in;
      vld_nxt = vld_in;
    end else begin
      if (ctl.acc_en && pbit) begin
        acc_nxt = acc_r ^ sym;
      end
      if (ctl.load) begin
        vld_nxt = ge;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      vld_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign acc = acc_r;
  assign vld = vld_r;

endmodule

FILE: design/streaming_symbol_hamming_encoder_core.sv
// streaming_symbol_hamming_encoder_core: top level of the streaming hamming encoder
// depends on shec_pkg and a row of shec_cell instances
//
// usage: data symbols arrive on the in_ channel, one per transfer, with in_last
// marking the final symbol of a codeword. each symbol leaves at once on the out_
// channel with its code position (check positions are skipped). a symbol past
// the usable length is flagged dropped with position 0. after the last symbol,
// the check symbols follow in rising position order, one per cycle while
// out_ready is high, then the state clears for the next codeword.
// each data result is registered and appears in the cycle after its input transfer.
// throughput: one symbol per cycle while out_ready is high; after a last symbol,
// the output then carries its check symbols (up to CHECK_COUNT), during which
// in_ready is low while the cell row shifts its check symbols out.
// the output register lets a new symbol enter while a result is taken; when
// out_ready is low the result holds and in_ready drops.
// reset clears the length, the check cells and the output valid.
module streaming_symbol_hamming_encoder_core #(
  parameter int MAX_LENGTH  = 65535,
  parameter int CHECK_COUNT = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [shec_pkg::SYM_W-1:0]  in_symbol,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [shec_pkg::POS_W-1:0]  out_position,
  output logic [shec_pkg::SYM_W-1:0]  out_value,
  output logic                        out_is_check,
  output logic                        out_dropped,
  output logic                        out_end_of_run
);

  localparam int PW        = shec_pkg::POS_W;
  localparam int CODE_SPAN = (1 << CHECK_COUNT) - 1;
  localparam int LEN_LIM_I = (MAX_LENGTH < CODE_SPAN) ? MAX_LENGTH : CODE_SPAN;
  localparam logic [PW:0] LEN_LIMIT = (PW+1)'(LEN_LIM_I);

  logic [PW-1:0]          len_r, len_nxt, len_upd;
  logic                   drain_r, drain_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PW-1:0]          out_pos_r, out_pos_nxt;
  logic [shec_pkg::SYM_W-1:0] out_val_r, out_val_nxt;
  logic                   out_chk_r, out_chk_nxt;
  logic                   out_drop_r, out_drop_nxt;
  logic                   out_end_r, out_end_nxt;

  logic [SYMBOL_BITS-1:0] sym;
  logic [PW:0]            l1, p;
  logic                   drop, take, slot_free, shift, done;
  logic [CHECK_COUNT-1:0] ge;
  logic [SYMBOL_BITS-1:0] acc [CHECK_COUNT+1];
  logic [CHECK_COUNT:0]   vld;
  logic [shec_pkg::SYM_W-1:0] chk_val;
  logic [shec_pkg::SYM_W-1:0] sym_val;
  shec_pkg::cell_ctl_t    ctl;

  assign sym = in_symbol[SYMBOL_BITS-1:0];

  always_comb begin
    l1 = {1'b0, len_r} + (PW+1)'(1);
    if (len_r == '0) begin
      p = (PW+1)'(3);
    end else if ((l1 & (l1 - (PW+1)'(1))) == '0) begin
      p = l1 + (PW+1)'(1);
    end else begin
      p = l1;
    end
  end

  assign drop      = (p > LEN_LIMIT);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = !drain_r && slot_free;
  assign take      = in_valid && in_ready;
  assign shift     = drain_r && slot_free;
  assign done      = shift && !vld[1];
  assign len_upd   = (take && !drop) ? p[PW-1:0] : len_r;

  assign ctl.acc_en = take && !drop;
  assign ctl.load   = take && in_last;
  assign ctl.shift  = shift;
  assign ctl.clear  = done;

  assign acc[CHECK_COUNT] = '0;
  assign vld[CHECK_COUNT] = 1'b0;

  genvar k;
  generate
    for (k = 0; k < CHECK_COUNT; k++) begin : g_cell
      assign ge[k] = |len_upd[PW-1:k];
      shec_cell #(.SYMBOL_BITS(SYMBOL_BITS)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sym    (sym),
        .pbit   (p[k]),
        .ge     (ge[k]),
        .acc_in (acc[k+1]),
        .vld_in (vld[k+1]),
        .acc    (acc[k]),
        .vld    (vld[k])
      );
    end
  endgenerate

  always_comb begin
    chk_val = '0;
    chk_val[SYMBOL_BITS-1:0] = acc[0];
    sym_val = '0;
    sym_val[SYMBOL_BITS-1:0] = sym;
  end

  always_comb begin
    len_nxt       = len_upd;
    drain_nxt     = drain_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_chk_nxt   = out_chk_r;
    out_drop_nxt  = out_drop_r;
    out_end_nxt   = out_end_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = drop ? '0 : p[PW-1:0];
      out_val_nxt   = sym_val;
      out_chk_nxt   = 1'b0;
      out_drop_nxt  = drop;
      out_end_nxt   = !in_last;
      if (in_last) begin
        len_nxt   = '0;
        drain_nxt = 1'b1;
        pos_nxt   = PW'(1);
      end
    end else if (shift) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_r;
      out_val_nxt   = chk_val;
      out_chk_nxt   = 1'b1;
      out_drop_nxt  = 1'b0;
      out_end_nxt   = !vld[1];
      pos_nxt       = {pos_r[PW-2:0], 1'b0};
      if (done) begin
        drain_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      drain_r     <= 1'b0;
      pos_r       <= PW'(1);
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      drain_r     <= drain_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_chk_r  <= out_chk_nxt;
    out_drop_r <= out_drop_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_pos_r;
  assign out_value      = out_val_r;
  assign out_is_check   = out_chk_r;
  assign out_dropped    = out_drop_r;
  assign out_end_of_run = out_end_r;

endmodule

FILE: design/shec_checker.sv
// shec_checker: port-level assertions for the streaming hamming encoder
// bound to streaming_symbol_hamming_encoder_core, depends on shec_pkg for widths
module shec_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [shec_pkg::SYM_W-1:0]  in_symbol,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [shec_pkg::POS_W-1:0]  out_position,
  input logic [shec_pkg::SYM_W-1:0]  out_value,
  input logic                        out_is_check,
  input logic                        out_dropped,
  input logic                        out_end_of_run
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_value)
      && $stable(out_is_check) && $stable(out_end_of_run))
    else $error("result changed while stalled");

  // check symbols sit at power-of-two positions
  a_chk_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_check |-> $onehot(out_position) && !out_dropped)
    else $error("check symbol at non power-of-two position");

  // dropped symbol has no position
  a_drop_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_position == '0 && !out_is_check)
    else $error("dropped symbol carries a position");

  // data symbols never land on a check position
  a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_check && !out_dropped |-> !$onehot0(out_position))
    else $error("data symbol on check position");

  // a check transfer that is not the end is followed by another check
  a_chk_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_check && !out_end_of_run |=> out_valid && out_is_check)
    else $error("check run cut short");

endmodule

bind streaming_symbol_hamming_encoder_core shec_checker u_shec_checker (.*);
